[hdl/sjis_string_compare_assert.svh]
// Assertion helpers shared by the queue and back-end RTL files.
// Each one expects clk_i and rst_ni to be visible where it is used.
`ifndef SJIS_STRING_COMPARE_ASSERT_SVH
`define SJIS_STRING_COMPARE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define SJIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define SJIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sjis_pkg.sv]
package sjis_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int LIMIT_W         = 16;
  localparam int OUTCOME_W       = 9;
  localparam int CFG_IDX_W       = 2;
  localparam int QUEUE_DEPTH     = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CASE_FOLD  = 2'd0,
    CFG_LIMIT_ON   = 2'd1,
    CFG_CHAR_LIMIT = 2'd2
  } sjis_cfg_e;

  // Character categories, ordered as they compare.
  typedef enum logic [1:0] {
    CAT_TERM   = 2'd0,
    CAT_SINGLE = 2'd1,
    CAT_KANA   = 2'd2,
    CAT_KANJI  = 2'd3
  } sjis_cat_e;

  localparam logic [7:0] KANA_LO = 8'hA1;
  localparam logic [7:0] KANA_HI = 8'hDF;

  localparam logic signed [OUTCOME_W-1:0] OUT_ZERO  = 9'sd0;
  localparam logic signed [OUTCOME_W-1:0] OUT_PLUS  = 9'sd1;
  localparam logic signed [OUTCOME_W-1:0] OUT_MINUS = -9'sd1;

  // One classified byte pair as it travels from front to back.
  typedef struct packed {
    logic [7:0]                  byte_a;
    logic [7:0]                  byte_b;
    logic                        first;
    sjis_cat_e                   cat_a;
    sjis_cat_e                   cat_b;
    logic signed [OUTCOME_W-1:0] sb_diff;
  } sjis_item_t;

endpackage

[hdl/sjis_front.sv]
module sjis_front (
  input  logic               case_fold_i,
  input  logic [7:0]         byte_a_i,
  input  logic [7:0]         byte_b_i,
  input  logic               first_i,
  output sjis_pkg::sjis_item_t item_o
);
  import sjis_pkg::*;

  function automatic sjis_cat_e classify(input logic [7:0] c);
    sjis_cat_e cat;
    if (c == 8'h00) begin
      cat = CAT_TERM;
    end else if ((c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hFC)) begin
      cat = CAT_KANJI;
    end else if (c >= KANA_LO && c <= KANA_HI) begin
      cat = CAT_KANA;
    end else begin
      cat = CAT_SINGLE;
    end
    return cat;
  endfunction

  function automatic logic [7:0] fold(input logic en, input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  logic [7:0] fold_a, fold_b;

  // Folding only touches A..Z, which are single-byte characters, so the
  // difference is correct for half-width kana as well.
  assign fold_a = fold(case_fold_i, byte_a_i);
  assign fold_b = fold(case_fold_i, byte_b_i);

  always_comb begin
    item_o.byte_a  = byte_a_i;
    item_o.byte_b  = byte_b_i;
    item_o.first   = first_i;
    item_o.cat_a   = classify(byte_a_i);
    item_o.cat_b   = classify(byte_b_i);
    item_o.sb_diff = $signed({1'b0, fold_a}) - $signed({1'b0, fold_b});
  end

endmodule

[hdl/sjis_queue.sv]
module sjis_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sjis_pkg::sjis_item_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output sjis_pkg::sjis_item_t item_o
);
  import sjis_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

  sjis_item_t       slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == DEPTH_C);
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

`include "sjis_string_compare_assert.svh"

  `SJIS_ASSERT_NOW(a_queue_no_overflow, push_i, !full_o || pop_i, "push into a full queue")
  `SJIS_ASSERT_NEXT(a_queue_drain, pop_i && !push_i, count_q == $past(count_q) - 1'b1, "pop lost")

endmodule

[hdl/sjis_back.sv]
module sjis_back #(
  parameter int COUNT_WIDTH = sjis_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  item_valid_i,
  input  sjis_pkg::sjis_item_t                  item_i,
  output logic                                  item_pop_o,
  input  logic                                  limit_on_i,
  input  logic [sjis_pkg::LIMIT_W-1:0]          char_limit_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [sjis_pkg::OUTCOME_W-1:0] outcome_o
);
  import sjis_pkg::*;

  localparam int WIDE_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam logic [WIDE_W-1:0] COUNT_MAX_W = WIDE_W'({COUNT_WIDTH{1'b1}});

  logic                   decided_q, decided_d;
  logic                   in_kanji_q, in_kanji_d;
  logic [7:0]             lead_a_q, lead_a_d, lead_b_q, lead_b_d;
  logic [COUNT_WIDTH-1:0] chars_q, chars_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [OUTCOME_W-1:0] outcome_q, outcome_d;

  logic                   fire;
  logic                   emit;
  logic signed [OUTCOME_W-1:0] result;
  logic [WIDE_W-1:0]      limit_wide;
  logic [COUNT_WIDTH-1:0] chars_load;
  logic                   dec_eff, kanji_eff;
  logic [7:0]             lead_a_eff, lead_b_eff;
  logic [COUNT_WIDTH-1:0] chars_eff, chars_dec;
  logic [15:0]            val_a, val_b;
  logic signed [OUTCOME_W-1:0] cat_diff;

  assign fire       = item_valid_i && (!out_valid_q || !out_stall_i);
  assign item_pop_o = fire;

  assign limit_wide = WIDE_W'(char_limit_i);
  assign chars_load = (limit_wide > COUNT_MAX_W) ? COUNT_WIDTH'(COUNT_MAX_W)
                                                 : COUNT_WIDTH'(limit_wide);

  // A first item restarts everything before it is evaluated.
  assign dec_eff    = item_i.first ? 1'b0 : decided_q;
  assign kanji_eff  = item_i.first ? 1'b0 : in_kanji_q;
  assign lead_a_eff = item_i.first ? 8'h00 : lead_a_q;
  assign lead_b_eff = item_i.first ? 8'h00 : lead_b_q;
  assign chars_eff  = item_i.first ? chars_load : chars_q;
  assign chars_dec  = (chars_eff != '0) ? chars_eff - 1'b1 : chars_eff;

  assign val_a    = {lead_a_eff, item_i.byte_a};
  assign val_b    = {lead_b_eff, item_i.byte_b};
  assign cat_diff = OUTCOME_W'($signed({1'b0, item_i.cat_a}))
                  - OUTCOME_W'($signed({1'b0, item_i.cat_b}));

  always_comb begin
    decided_d  = dec_eff;
    in_kanji_d = kanji_eff;
    lead_a_d   = lead_a_eff;
    lead_b_d   = lead_b_eff;
    chars_d    = chars_eff;
    emit       = 1'b0;
    result     = OUT_ZERO;
    if (dec_eff) begin
      emit = 1'b0;
    end else if (kanji_eff) begin
      in_kanji_d = 1'b0;
      if (val_a != val_b) begin
        emit   = 1'b1;
        result = (val_a > val_b) ? OUT_PLUS : OUT_MINUS;
      end else if (item_i.byte_a == 8'h00) begin
        emit = 1'b1;
      end else begin
        chars_d = chars_dec;
        emit    = limit_on_i && (chars_dec == '0);
      end
    end else if (limit_on_i && chars_eff == '0) begin
      emit = 1'b1;
    end else if (item_i.byte_a == 8'h00 && item_i.byte_b == 8'h00) begin
      emit = 1'b1;
    end else if (item_i.cat_a != item_i.cat_b) begin
      emit   = 1'b1;
      result = cat_diff;
    end else if (item_i.cat_a == CAT_KANJI) begin
      lead_a_d   = item_i.byte_a;
      lead_b_d   = item_i.byte_b;
      in_kanji_d = 1'b1;
    end else if (item_i.sb_diff != OUT_ZERO) begin
      emit   = 1'b1;
      result = item_i.sb_diff;
    end else begin
      chars_d = chars_dec;
      emit    = limit_on_i && (chars_dec == '0);
    end
    if (emit) begin
      decided_d  = 1'b1;
      in_kanji_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    outcome_d   = outcome_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
      outcome_d   = result;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decided_q   <= 1'b1;
      in_kanji_q  <= 1'b0;
      lead_a_q    <= 8'h00;
      lead_b_q    <= 8'h00;
      chars_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        decided_q  <= decided_d;
        in_kanji_q <= in_kanji_d;
        lead_a_q   <= lead_a_d;
        lead_b_q   <= lead_b_d;
        chars_q    <= chars_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    outcome_q <= outcome_d;
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o   = outcome_q;

`include "sjis_string_compare_assert.svh"

  `SJIS_ASSERT_NOW(a_back_kanji_open, in_kanji_q, !decided_q, "kanji pending after decision")
  `SJIS_ASSERT_NEXT(a_back_emit_closes, fire && emit, decided_q && out_valid_q, "emit not recorded")

endmodule

[hdl/sjis_string_compare.sv]
// SJIS aware string compare. Two strings stream in lockstep, one byte of
// each per input transaction, and each decided comparison yields exactly one
// output transaction whose signed outcome orders the first string against the
// second: a category difference (terminator < single byte < half-width kana <
// kanji), +1 or -1 for differing kanji, or the byte difference of single-byte
// characters (A..Z folded to lower case when case_fold is set). An input with
// first set starts a new comparison and abandons any open one; inputs arriving
// after a comparison is decided are dropped until the next first. The block
// accepts one byte pair per clock cycle while in_stall is low. A pair is
// classified on entry and lands in a two-entry queue; the compare stage takes
// the queue head from there and registers its outcome, so the outcome of a
// deciding pair passes through the queue and the output register before it
// can be taken. The compare stage retires one pair per cycle as long as the
// output register is free or being emptied, and the queue absorbs a stalled
// output so input stall rises only once it is full. Configuration (case_fold,
// limit_on, char_limit) is to be written by the user through the plain write
// port only while no transaction is in flight; the block does not enforce it.
module sjis_string_compare #(
  parameter int COUNT_WIDTH = sjis_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input transactions.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [7:0]                            byte_a_i,
  input  logic [7:0]                            byte_b_i,
  input  logic                                  first_i,
  // Output transactions.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [sjis_pkg::OUTCOME_W-1:0] outcome_o,
  // Configuration writes.
  input  logic                                  cfg_we_i,
  input  logic [sjis_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sjis_pkg::LIMIT_W-1:0]          cfg_data_i
);
  import sjis_pkg::*;

  // Configuration registers.
  logic               case_fold_q;
  logic               limit_on_q;
  logic [LIMIT_W-1:0] char_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_fold_q  <= 1'b0;
      limit_on_q   <= 1'b0;
      char_limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CASE_FOLD:  case_fold_q  <= cfg_data_i[0];
        CFG_LIMIT_ON:   limit_on_q   <= cfg_data_i[0];
        CFG_CHAR_LIMIT: char_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: classify the incoming pair and push it into the queue.
  sjis_item_t front_item, back_item;
  logic       q_full, q_valid, q_pop, q_push;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  sjis_front u_front (
    .case_fold_i (case_fold_q),
    .byte_a_i    (byte_a_i),
    .byte_b_i    (byte_b_i),
    .first_i     (first_i),
    .item_o      (front_item)
  );

  sjis_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (back_item)
  );

  // Back end: comparison state and the output register.
  sjis_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (back_item),
    .item_pop_o   (q_pop),
    .limit_on_i   (limit_on_q),
    .char_limit_i (char_limit_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .outcome_o    (outcome_o)
  );

endmodule
